// File: design/mchw_pkg.sv
// Shared constants and codes for the multi-channel heartbeat watchdog.
package mchw_pkg;

  // Default sizes of the channel table.
  localparam int CHANNELS_DEF    = 16;
  localparam int PERIOD_BITS_DEF = 16;

  // Fixed field widths.
  localparam int OP_W     = 3;
  localparam int CH_FIELD_W = 5;
  localparam int IN_PER_W = 16;
  localparam int WINDOW_W = 16;
  localparam int FAIL_W   = 8;
  localparam int STEP_W   = 8;
  localparam int SKIP_W   = 16;
  localparam int STATUS_W = 2;
  localparam int FAILED_W = 4;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_FEED      = 3'd0;
  localparam logic [OP_W-1:0] OP_SET       = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK      = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_CH  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RESTART = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_MONITOR_ENABLE = 3'd0;
  localparam logic [2:0] REG_FAILURE_LIMIT  = 3'd1;
  localparam logic [2:0] REG_TICK_STEP      = 3'd2;
  localparam logic [2:0] REG_ONE_SHOT       = 3'd3;
  localparam logic [2:0] REG_SKIP_MASK      = 3'd4;

  // Register reset values.
  localparam logic [FAIL_W-1:0] FAIL_LIMIT_RST = 8'd3;
  localparam logic [STEP_W-1:0] TICK_STEP_RST  = 8'd1;

  // Saturation limits.
  localparam logic [WINDOW_W-1:0] WINDOW_MAX = 16'hFFFF;
  localparam logic [FAIL_W-1:0]   FAIL_MAX   = 8'hFF;

endpackage

// File: design/mchw_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module mchw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/multi_channel_heartbeat_watchdog.sv
// Top level: heartbeat watchdog with its channel table held in one RAM.
// A request that visits no channel gives its result the cycle after acceptance; feed, set
// and clear give it once their channel is written back, clear all and tick after the sweep.
// Busy holds until the result is given; the three-stage read, multiply, write-back pipeline
// over the table RAM handles one channel per cycle, and a tick sweep stops early on a restart.
// Results are single-cycle strobes; the receiver cannot stall them.
// Reset loads the register defaults and clears one valid bit per table entry, so the whole
// table reads as zero straight away; no clearing pass is needed.
module multi_channel_heartbeat_watchdog import mchw_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [CH_FIELD_W-1:0] in_channel,
  input  logic                  in_check_enable,
  input  logic [IN_PER_W-1:0]   in_period,
  // Result channel
  output logic                  out_strobe,
  output logic [STATUS_W-1:0]   out_status,
  output logic [FAILED_W-1:0]   out_failed_channel,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  localparam int AW     = $clog2(CHANNELS);
  localparam int PB     = PERIOD_BITS;
  localparam int WORD_W = PB + WINDOW_W + FAIL_W + 2;
  localparam int EL_W   = WINDOW_W + 1 + STEP_W;
  localparam int LIM_W  = PB + FAIL_W + 1;
  localparam int CMP_W  = (LIM_W > EL_W) ? LIM_W : EL_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  // Configuration registers
  logic              mon_en_r;
  logic [FAIL_W-1:0] fail_lim_r;
  logic [STEP_W-1:0] tick_step_r;
  logic [3:0]        one_shot_r;
  logic [SKIP_W-1:0] skip_mask_r;
  logic              cfg_wr;
  logic [2:0]        reg_idx;

  // Control
  state_t            state_r;
  logic [OP_W-1:0]   op_r;
  logic              chk_en_r;
  logic [PB-1:0]     per_r;
  logic              single_r;
  logic              accept;
  logic              bad_ch;
  logic              is_single;
  logic              is_sweep;
  logic              visit;

  // Pipeline
  logic              iss_act_r;
  logic [AW-1:0]     iss_addr_r;
  logic              iss_last;
  logic              s1_vld_r;
  logic              s1_ok_r;
  logic              s1_last_r;
  logic [AW-1:0]     s1_addr_r;
  logic              s2_vld_r;
  logic              s2_last_r;
  logic [AW-1:0]     s2_addr_r;
  logic              s2_en_r;
  logic              s2_fed_r;
  logic [PB-1:0]     s2_per_r;
  logic [WINDOW_W-1:0] s2_win_r;
  logic [FAIL_W-1:0] s2_fail_r;
  logic [EL_W-1:0]   elapsed_r;
  logic [LIM_W-1:0]  lim_r;
  logic [CHANNELS-1:0] ram_vld_r;

  // Table RAM
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_we;
  logic [WORD_W-1:0] rd_word;
  logic              d_en;
  logic              d_fed;
  logic [PB-1:0]     d_per;
  logic [WINDOW_W-1:0] d_win;
  logic [FAIL_W-1:0] d_fail;
  logic [EL_W-1:0]   elapsed_nxt;
  logic [LIM_W-1:0]  lim_nxt;

  // Update logic
  logic [CHANNELS-1:0] skip_ext;
  logic              is_os;
  logic              reach;
  logic [WINDOW_W-1:0] win_inc;
  logic [FAIL_W-1:0] fail_inc;
  logic              n_en;
  logic              n_fed;
  logic [PB-1:0]     n_per;
  logic [WINDOW_W-1:0] n_win;
  logic [FAIL_W-1:0] n_fail;
  logic              upd_wr;
  logic              restart;
  logic              finish;

  // Output registers
  logic                out_strobe_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [FAILED_W-1:0] out_failed_r;

  // Configuration writes and reads.
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mon_en_r    <= 1'b1;
      fail_lim_r  <= FAIL_LIMIT_RST;
      tick_step_r <= TICK_STEP_RST;
      one_shot_r  <= '0;
      skip_mask_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MONITOR_ENABLE: mon_en_r    <= pwdata[0];
        REG_FAILURE_LIMIT:  fail_lim_r  <= pwdata[FAIL_W-1:0];
        REG_TICK_STEP:      tick_step_r <= pwdata[STEP_W-1:0];
        REG_ONE_SHOT:       one_shot_r  <= pwdata[3:0];
        REG_SKIP_MASK:      skip_mask_r <= pwdata[SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MONITOR_ENABLE: prdata = DATA_W'(mon_en_r);
      REG_FAILURE_LIMIT:  prdata = DATA_W'(fail_lim_r);
      REG_TICK_STEP:      prdata = DATA_W'(tick_step_r);
      REG_ONE_SHOT:       prdata = DATA_W'(one_shot_r);
      REG_SKIP_MASK:      prdata = DATA_W'(skip_mask_r);
      default:            prdata = '0;
    endcase
  end

  // Request decode.
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign is_single = (in_operation == OP_FEED) || (in_operation == OP_SET) ||
                     (in_operation == OP_CLEAR);
  assign is_sweep  = (in_operation == OP_CLEAR_ALL) || (in_operation == OP_TICK);
  assign bad_ch    = is_single && (32'(in_channel) >= CHANNELS);
  assign visit     = mon_en_r && !bad_ch && (is_single || is_sweep);

  assign iss_last  = single_r || (iss_addr_r == AW'(CHANNELS - 1));

  // Read stage: an entry that was never written reads as zero.
  assign rd_word     = s1_ok_r ? ram_rdata : '0;
  assign d_fail      = rd_word[FAIL_W-1:0];
  assign d_win       = rd_word[FAIL_W +: WINDOW_W];
  assign d_per       = rd_word[FAIL_W + WINDOW_W +: PB];
  assign d_fed       = rd_word[WORD_W-2];
  assign d_en        = rd_word[WORD_W-1];
  assign elapsed_nxt = (EL_W'(d_win) + EL_W'(1)) * EL_W'(tick_step_r);
  assign lim_nxt     = LIM_W'(d_per) * (LIM_W'(d_fail) + LIM_W'(1));

  // Write-back stage: the new contents of one channel.
  assign skip_ext = CHANNELS'(skip_mask_r);
  assign is_os    = (32'(s2_addr_r) == 32'(one_shot_r));
  assign reach    = CMP_W'(elapsed_r) >= CMP_W'(lim_r);
  assign win_inc  = (s2_win_r == WINDOW_MAX) ? s2_win_r : s2_win_r + WINDOW_W'(1);
  assign fail_inc = (s2_fail_r == FAIL_MAX) ? s2_fail_r : s2_fail_r + FAIL_W'(1);

  always_comb begin
    n_en    = s2_en_r;
    n_fed   = s2_fed_r;
    n_per   = s2_per_r;
    n_win   = s2_win_r;
    n_fail  = s2_fail_r;
    upd_wr  = 1'b0;
    restart = 1'b0;
    unique case (op_r)
      OP_FEED: begin
        if (s2_en_r) begin
          n_fed  = 1'b1;
          upd_wr = 1'b1;
        end
      end
      OP_SET: begin
        if (!chk_en_r && s2_en_r) begin
          n_fed  = 1'b0;
          n_win  = '0;
          n_fail = '0;
        end
        n_en   = chk_en_r;
        n_per  = per_r;
        upd_wr = 1'b1;
      end
      OP_CLEAR: begin
        n_fed  = 1'b0;
        n_win  = '0;
        n_fail = '0;
        upd_wr = 1'b1;
      end
      OP_CLEAR_ALL: begin
        n_win  = '0;
        n_fail = '0;
        if (!is_os) begin
          n_fed = 1'b0;
        end
        upd_wr = 1'b1;
      end
      OP_TICK: begin
        if (!skip_ext[s2_addr_r] && s2_en_r && (s2_per_r != '0)) begin
          upd_wr = 1'b1;
          if (is_os) begin
            // The one-shot channel retires on its first feed.
            if (s2_fed_r) begin
              n_en   = 1'b0;
              n_fed  = 1'b0;
              n_win  = '0;
              n_fail = '0;
            end else if (reach) begin
              n_fail  = fail_inc;
              restart = (fail_inc >= fail_lim_r);
              if (!restart) begin
                n_win = win_inc;
              end
            end else begin
              n_win = win_inc;
            end
          end else if (reach) begin
            if (s2_fed_r) begin
              n_fed  = 1'b0;
              n_win  = '0;
              n_fail = '0;
            end else begin
              n_fail  = fail_inc;
              n_win   = win_inc;
              restart = (fail_inc >= fail_lim_r);
            end
          end else begin
            n_win = win_inc;
          end
        end
      end
      default: ;
    endcase
  end

  assign ram_we    = s2_vld_r && upd_wr;
  assign ram_wdata = {n_en, n_fed, n_per, n_win, n_fail};
  assign finish    = s2_vld_r && (restart || s2_last_r);

  mchw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CHANNELS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s2_addr_r),
    .wdata (ram_wdata),
    .re    (iss_act_r),
    .raddr (iss_addr_r),
    .rdata (ram_rdata)
  );

  // Sequencer, pipeline control and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      iss_act_r    <= 1'b0;
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      ram_vld_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (ram_we) begin
        ram_vld_r[s2_addr_r] <= 1'b1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (visit) begin
              state_r    <= ST_RUN;
              iss_act_r  <= 1'b1;
              iss_addr_r <= is_single ? in_channel[AW-1:0] : '0;
              single_r   <= is_single;
            end else begin
              out_strobe_r <= 1'b1;
              out_status_r <= (mon_en_r && bad_ch) ? STATUS_BAD_CH : STATUS_OK;
              out_failed_r <= '0;
            end
          end
        end
        ST_RUN: begin
          if (iss_act_r) begin
            if (iss_last) begin
              iss_act_r <= 1'b0;
            end else begin
              iss_addr_r <= iss_addr_r + AW'(1);
            end
          end
          s1_vld_r <= iss_act_r;
          s2_vld_r <= s1_vld_r;
          if (finish) begin
            // Last channel written back, or a tick stopped on a restart.
            state_r      <= ST_IDLE;
            iss_act_r    <= 1'b0;
            s1_vld_r     <= 1'b0;
            s2_vld_r     <= 1'b0;
            out_strobe_r <= 1'b1;
            out_status_r <= restart ? STATUS_RESTART : STATUS_OK;
            out_failed_r <= restart ? FAILED_W'(s2_addr_r) : '0;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Request fields and pipeline payload need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_operation;
      chk_en_r <= in_check_enable;
      per_r    <= PB'(in_period);
    end
    s1_addr_r <= iss_addr_r;
    s1_last_r <= iss_last;
    s1_ok_r   <= ram_vld_r[iss_addr_r];
    s2_addr_r <= s1_addr_r;
    s2_last_r <= s1_last_r;
    s2_en_r   <= d_en;
    s2_fed_r  <= d_fed;
    s2_per_r  <= d_per;
    s2_win_r  <= d_win;
    s2_fail_r <= d_fail;
    elapsed_r <= elapsed_nxt;
    lim_r     <= lim_nxt;
  end

  assign out_strobe         = out_strobe_r;
  assign out_status         = out_status_r;
  assign out_failed_channel = out_failed_r;

  // A result is only ever presented once the block has gone idle.
  assert property (@(posedge clk) disable iff (!rst_n) out_strobe |-> !busy)
    else $error("result strobe while busy");

  // A request that touches no channel is answered in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) (accept && !visit) |=> out_strobe)
    else $error("direct request not answered next cycle");

  // Only a tick can ask for a restart.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_strobe && (out_status == STATUS_RESTART)) |-> (op_r == OP_TICK))
    else $error("restart status from a request other than tick");

  // A restart found in write-back ends the walk at once.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (s2_vld_r && restart) |=> (!busy && out_strobe && !s2_vld_r))
    else $error("walk not stopped after restart");

  // The table is only written while a request is being worked on.
  assert property (@(posedge clk) disable iff (!rst_n) ram_we |-> (state_r == ST_RUN))
    else $error("table write outside a request");

endmodule
